### rtl/core/ack_reply_number_parser_macros.svh
// assertion macros for the ack reply number parser checker
// used by arnp_checker.sv only, no other dependencies
`ifndef ACK_REPLY_NUMBER_PARSER_MACROS_SVH
`define ACK_REPLY_NUMBER_PARSER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, quiet in reset
`define ARNP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arnp checker: same-cycle rule violated");

// next-cycle implication, sampled on the rising clock, quiet in reset
`define ARNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arnp checker: next-cycle rule violated");

`endif

### rtl/core/arnp_pkg.sv
// shared types and constants of the ack reply number parser
// no dependencies; used by every module of the block
package arnp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 27;
    localparam int unsigned DIGITS_W = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TDATA_W  = 32;

    // longest integer part accepted before the point
    localparam logic [DIGITS_W-1:0] MAX_INT_DIGITS = 3'd6;

    localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd20;

    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HASH1 = 3'd1,
        PH_HASH2 = 3'd2,
        PH_A     = 3'd3,
        PH_C     = 3'd4,
        PH_INT   = 3'd5,
        PH_FRAC0 = 3'd6,
        PH_FRAC1 = 3'd7
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PENDING = 2'd0,
        ST_DONE    = 2'd1,
        ST_FAIL    = 2'd2
    } status_t;

    typedef struct packed {
        phase_t               phase;
        logic [BYTE_W-1:0]    idle_misses;
        logic [VALUE_W-1:0]   accumulator;
        logic [DIGITS_W-1:0]  int_digits;
    } parse_state_t;

endpackage

### rtl/core/arnp_step.sv
// combinational parse step: one byte against the current parse state
// depends on arnp_pkg
module arnp_step
(
    input  arnp_pkg::parse_state_t          cur,
    input  logic [arnp_pkg::BYTE_W-1:0]     idle_miss_limit,
    input  logic [arnp_pkg::BYTE_W-1:0]     rx_byte,
    output arnp_pkg::parse_state_t          nxt,
    output arnp_pkg::status_t               status,
    output logic [arnp_pkg::VALUE_W-1:0]    value_hundredths
);

    logic                              is_digit;
    logic [3:0]                        digit;
    logic [arnp_pkg::BYTE_W-1:0]       byte_off;
    logic [arnp_pkg::BYTE_W-1:0]       misses_inc;
    logic [arnp_pkg::VALUE_W-1:0]      acc_x10;

    assign is_digit   = (rx_byte >= arnp_pkg::CH_0) && (rx_byte <= arnp_pkg::CH_9);
    assign byte_off   = rx_byte - arnp_pkg::CH_0;
    assign digit      = byte_off[3:0];
    assign misses_inc = cur.idle_misses + 8'd1;
    // times ten as two shifts plus the new digit, wrapping at the field width
    assign acc_x10    = {cur.accumulator[arnp_pkg::VALUE_W-4:0], 3'b000}
                      + {cur.accumulator[arnp_pkg::VALUE_W-2:0], 1'b0}
                      + {{(arnp_pkg::VALUE_W-4){1'b0}}, digit};

    always_comb
    begin
        logic fail;
        fail             = 1'b0;
        nxt              = cur;
        status           = arnp_pkg::ST_PENDING;
        value_hundredths = '0;

        unique case (cur.phase)
            arnp_pkg::PH_IDLE:
            begin
                if (rx_byte == arnp_pkg::CH_HASH)
                begin
                    nxt.idle_misses = '0;
                    nxt.phase       = arnp_pkg::PH_HASH1;
                end
                else if (misses_inc >= idle_miss_limit)
                begin
                    nxt.idle_misses = '0;
                    status          = arnp_pkg::ST_FAIL;
                end
                else
                begin
                    nxt.idle_misses = misses_inc;
                end
            end
            arnp_pkg::PH_HASH1:
            begin
                if (rx_byte == arnp_pkg::CH_HASH) nxt.phase = arnp_pkg::PH_HASH2;
                else fail = 1'b1;
            end
            arnp_pkg::PH_HASH2:
            begin
                if (rx_byte == arnp_pkg::CH_A) nxt.phase = arnp_pkg::PH_A;
                else fail = 1'b1;
            end
            arnp_pkg::PH_A:
            begin
                if (rx_byte == arnp_pkg::CH_C) nxt.phase = arnp_pkg::PH_C;
                else fail = 1'b1;
            end
            arnp_pkg::PH_C:
            begin
                if (rx_byte == arnp_pkg::CH_K) nxt.phase = arnp_pkg::PH_INT;
                else fail = 1'b1;
            end
            arnp_pkg::PH_INT:
            begin
                if (is_digit && (cur.int_digits < arnp_pkg::MAX_INT_DIGITS))
                begin
                    nxt.accumulator = acc_x10;
                    nxt.int_digits  = cur.int_digits + 3'd1;
                end
                else if (rx_byte == arnp_pkg::CH_POINT)
                    nxt.phase = arnp_pkg::PH_FRAC0;
                else
                    fail = 1'b1;
            end
            arnp_pkg::PH_FRAC0:
            begin
                if (is_digit)
                begin
                    nxt.accumulator = acc_x10;
                    nxt.phase       = arnp_pkg::PH_FRAC1;
                end
                else
                    fail = 1'b1;
            end
            arnp_pkg::PH_FRAC1:
            begin
                if (is_digit)
                begin
                    value_hundredths = acc_x10;
                    status           = arnp_pkg::ST_DONE;
                    nxt.phase        = arnp_pkg::PH_IDLE;
                    nxt.accumulator  = '0;
                    nxt.int_digits   = '0;
                end
                else
                    fail = 1'b1;
            end
            default:
            begin
                fail = 1'b1;
            end
        endcase

        // unexpected byte: restart, the miss count is left alone
        if (fail)
        begin
            status          = arnp_pkg::ST_FAIL;
            nxt.phase       = arnp_pkg::PH_IDLE;
            nxt.accumulator = '0;
            nxt.int_digits  = '0;
        end
    end

endmodule

### rtl/core/ack_reply_number_parser.sv
// top level of the ack reply number parser: input register, parse state, result register
// depends on arnp_pkg and arnp_step
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata[7:0] rx_byte
//  m_*     | out | m_tvalid/m_tready  | m_tdata[26:0] value_hundredths, m_tuser status
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data[7:0] idle_miss_limit
//
//  one word per clock in steady state while m_* does not stall; from s_* acceptance a
//  word goes to the input register, then through the parse step to the result register
//  rst_n clears the parse state, both valid flags and sets the limit to 20
//  a stall on m_* holds the result; one more word waits in the input register,
//  after which s_tready drops until the result is taken
module ack_reply_number_parser
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [7:0] rx_byte

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [arnp_pkg::TDATA_W-1:0]    m_tdata,    // [26:0] value_hundredths, rest zero
    output logic [arnp_pkg::STATUS_W-1:0]   m_tuser,    // [1:0] status

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [7:0]                      cfg_data    // [7:0] idle_miss_limit
);

    // input register
    logic                               in_valid_reg;
    logic [arnp_pkg::BYTE_W-1:0]        in_data_reg;

    // parse state and limit register
    arnp_pkg::parse_state_t             state_reg;
    arnp_pkg::parse_state_t             state_next;
    logic [arnp_pkg::BYTE_W-1:0]        limit_reg;

    // result register
    logic                               out_valid_reg;
    arnp_pkg::status_t                  out_status_reg;
    arnp_pkg::status_t                  status_next;
    logic [arnp_pkg::VALUE_W-1:0]       out_value_reg;
    logic [arnp_pkg::VALUE_W-1:0]       value_next;

    logic                               advance;
    logic                               step_fire;

    // the result slot is free or is being emptied this cycle
    assign advance   = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    arnp_step u_step
    (
        .cur              (state_reg),
        .idle_miss_limit  (limit_reg),
        .rx_byte          (in_data_reg),
        .nxt              (state_next),
        .status           (status_next),
        .value_hundredths (value_next)
    );

    // control: valid flags, parse state, limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: arnp_pkg::PH_IDLE, idle_misses: '0,
                               accumulator: '0, int_digits: '0};
            limit_reg     <= arnp_pkg::LIMIT_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (step_fire)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata;
        if (step_fire)
        begin
            out_status_reg <= status_next;
            out_value_reg  <= value_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(arnp_pkg::TDATA_W-arnp_pkg::VALUE_W){1'b0}}, out_value_reg};

endmodule

### rtl/core/arnp_checker.sv
// port-level checker for ack_reply_number_parser, bound to the top level
// depends on arnp_pkg and ack_reply_number_parser_macros.svh
`include "ack_reply_number_parser_macros.svh"

module arnp_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [arnp_pkg::TDATA_W-1:0]    m_tdata,
    input  logic [arnp_pkg::STATUS_W-1:0]   m_tuser
);

    // only a completed number carries a value
    `ARNP_ASSERT_NOW(a_value_only_when_done, clk, rst_n,
        m_tvalid && (m_tuser != arnp_pkg::ST_DONE), m_tdata == '0)

    // status is one of pending, done, fail
    `ARNP_ASSERT_NOW(a_status_legal, clk, rst_n,
        m_tvalid, (m_tuser == arnp_pkg::ST_PENDING) || (m_tuser == arnp_pkg::ST_DONE)
        || (m_tuser == arnp_pkg::ST_FAIL))

    // with the result slot empty the input side never stalls
    `ARNP_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)

    // a stalled result holds its word
    `ARNP_ASSERT_NEXT(a_stall_holds, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind ack_reply_number_parser arnp_checker u_arnp_checker (.*);
